@@ src/bfa_pkg.sv @@
package bfa_pkg;

  // Default build sizes
  localparam int DEF_MAP_BITS       = 8192;
  localparam int DEF_SCAN_WORD_BITS = 32;

  // Field widths
  localparam int NUM_W  = 14;
  localparam int STAT_W = 2;

  // Map size register after reset
  localparam logic [NUM_W-1:0] MAP_SIZE_RESET = 14'd8192;

  // Used count saturation point
  localparam logic [NUM_W-1:0] USED_MAX = 14'h3FFF;

  // Operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic             operation;
    logic [NUM_W-1:0] entry_number;
  } bfa_in_t;

  typedef struct packed {
    logic [NUM_W-1:0]  allocated_number;
    logic [STAT_W-1:0] status;
    logic [NUM_W-1:0]  used_count;
  } bfa_out_t;

endpackage

@@ src/bfa_ram.sv @@
module bfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/bitmap_first_free_allocator_top.sv @@
// Allocate: words are scanned from word 0; the first free entry is set and its number returned,
// or full status when the scan of the words below the map size finds none.
// One bitmap word is tested per cycle through the single read port of the bitmap RAM.
// Free: constant divide (estimate, correction), read, write; a rejected free or a zero-size
// allocate goes straight to its result. One transaction is in work at a time; the next is
// taken once the result is registered. Reset (rst_n low, synchronous) starts a clearing pass.
module bitmap_first_free_allocator_top #(
  parameter int MAP_BITS       = bfa_pkg::DEF_MAP_BITS,
  parameter int SCAN_WORD_BITS = bfa_pkg::DEF_SCAN_WORD_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  bfa_pkg::bfa_in_t            in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output bfa_pkg::bfa_out_t           out_data,
  input  logic                        cfg_wen,
  input  logic [bfa_pkg::NUM_W-1:0]   cfg_wdata
);

  import bfa_pkg::*;

  localparam int WORD_COUNT = (MAP_BITS + SCAN_WORD_BITS - 1) / SCAN_WORD_BITS;
  localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int SZ_RAW     = $clog2(WORD_COUNT * SCAN_WORD_BITS + 1);
  localparam int SZ_W       = (SZ_RAW > NUM_W + 1) ? SZ_RAW : NUM_W + 1;
  localparam int BW         = $clog2(SCAN_WORD_BITS);
  localparam int PROD_W     = SZ_W + 33;
  localparam logic [32:0] RECIP = 33'((64'd1 << 32) / SCAN_WORD_BITS);

  localparam logic [AW-1:0]   LAST_WORD = AW'(WORD_COUNT - 1);
  localparam logic [SZ_W-1:0] SCAN_SZ   = SZ_W'(SCAN_WORD_BITS);
  localparam logic [SZ_W-1:0] MAP_SZ    = SZ_W'(MAP_BITS);

  // Sequencer states
  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_SCAN = 4'd2;
  localparam logic [3:0] S_AWR  = 4'd3;
  localparam logic [3:0] S_FDIV = 4'd4;
  localparam logic [3:0] S_FCOR = 4'd5;
  localparam logic [3:0] S_FRD  = 4'd6;
  localparam logic [3:0] S_FWR  = 4'd7;
  localparam logic [3:0] S_EMIT = 4'd8;

  logic [3:0]                state_r, state_nxt;
  logic [NUM_W-1:0]          map_size_r;
  logic [NUM_W-1:0]          used_r, used_nxt;
  logic [AW-1:0]             clr_r, clr_nxt;
  logic [SZ_W-1:0]           size_r, size_nxt;

  // Scan issue and check stage
  logic [AW-1:0]             rd_word_r, rd_word_nxt;
  logic [SZ_W-1:0]           rd_base_r, rd_base_nxt;
  logic                      iss_done_r, iss_done_nxt;
  logic                      chk_vld_r, chk_vld_nxt;
  logic [AW-1:0]             chk_word_r, chk_word_nxt;
  logic [SZ_W-1:0]           chk_base_r, chk_base_nxt;
  logic [SCAN_WORD_BITS-1:0] chk_mask_r, chk_mask_nxt;
  logic                      chk_last_r, chk_last_nxt;
  logic [SCAN_WORD_BITS-1:0] hold_r, hold_nxt;
  logic [SCAN_WORD_BITS-1:0] iso_r, iso_nxt;

  // Free path
  logic [SZ_W-1:0]           idx_r, idx_nxt;
  logic [SZ_W-1:0]           q_r, q_nxt;
  logic [AW-1:0]             fword_r, fword_nxt;
  logic [BW-1:0]             fbit_r, fbit_nxt;

  // Result and output register
  bfa_out_t                  res_r, res_nxt;
  logic                      out_valid_r, out_valid_nxt;
  bfa_out_t                  out_data_r, out_data_nxt;

  // RAM port
  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [SCAN_WORD_BITS-1:0] ram_wdata;
  logic [AW-1:0]             ram_raddr;
  logic [SCAN_WORD_BITS-1:0] ram_rdata;

  // Shared combinational terms
  logic                      accept;
  logic [SZ_W-1:0]           eff_size;
  logic [SZ_W-1:0]           num_ext;
  logic [SZ_W-1:0]           rem;
  logic [SCAN_WORD_BITS-1:0] iss_mask;
  logic                      iss_last;
  logic [SCAN_WORD_BITS-1:0] free_bits;
  logic [BW-1:0]             enc;
  logic [PROD_W-1:0]         prod;
  logic [SZ_W-1:0]           frem;

  bfa_ram #(
    .WIDTH (SCAN_WORD_BITS),
    .DEPTH (WORD_COUNT)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Clamp the configured size to the map
  assign eff_size = (SZ_W'(map_size_r) > MAP_SZ) ? MAP_SZ : SZ_W'(map_size_r);
  assign num_ext  = SZ_W'(in_data.entry_number);

  // Entries of the word being issued that lie below the map size
  assign rem      = size_r - rd_base_r;
  assign iss_last = ((SZ_W + 1)'(rd_base_r) + (SZ_W + 1)'(SCAN_SZ)) >= (SZ_W + 1)'(size_r);
  always_comb begin
    for (int b = 0; b < SCAN_WORD_BITS; b++) begin
      iss_mask[b] = (SZ_W'(b) < rem);
    end
  end

  assign free_bits = ~ram_rdata & chk_mask_r;

  // Encode the isolated free bit
  always_comb begin
    enc = '0;
    for (int b = 0; b < SCAN_WORD_BITS; b++) begin
      if (iso_r[b]) begin
        enc = enc | BW'(b);
      end
    end
  end

  // Divide the free index by the word size through a reciprocal
  assign prod = PROD_W'(idx_r) * PROD_W'(RECIP);
  assign frem = idx_r - SZ_W'(q_r * SCAN_SZ);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    clr_nxt       = clr_r;
    size_nxt      = size_r;
    rd_word_nxt   = rd_word_r;
    rd_base_nxt   = rd_base_r;
    iss_done_nxt  = iss_done_r;
    chk_vld_nxt   = chk_vld_r;
    chk_word_nxt  = chk_word_r;
    chk_base_nxt  = chk_base_r;
    chk_mask_nxt  = chk_mask_r;
    chk_last_nxt  = chk_last_r;
    hold_nxt      = hold_r;
    iso_nxt       = iso_r;
    idx_nxt       = idx_r;
    q_nxt         = q_r;
    fword_nxt     = fword_r;
    fbit_nxt      = fbit_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = clr_r;
    ram_wdata     = '0;
    ram_raddr     = rd_word_r;

    case (state_r)
      S_CLR: begin
        // Zero one bitmap word per cycle
        ram_we  = 1'b1;
        clr_nxt = AW'(clr_r + 1'b1);
        if (clr_r == LAST_WORD) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          size_nxt                 = eff_size;
          res_nxt.allocated_number = '0;
          res_nxt.status           = ST_OK;
          res_nxt.used_count       = '0;
          if (in_data.operation == OP_ALLOC) begin
            rd_word_nxt  = '0;
            rd_base_nxt  = '0;
            iss_done_nxt = 1'b0;
            chk_vld_nxt  = 1'b0;
            if (eff_size == '0) begin
              res_nxt.status = ST_FULL;
              state_nxt      = S_EMIT;
            end else begin
              state_nxt = S_SCAN;
            end
          end else begin
            idx_nxt = num_ext - 1'b1;
            if (num_ext == '0 || num_ext > eff_size) begin
              res_nxt.status = ST_RANGE;
              state_nxt      = S_EMIT;
            end else begin
              state_nxt = S_FDIV;
            end
          end
        end
      end

      S_SCAN: begin
        if (chk_vld_r && free_bits != '0) begin
          // Hit: keep the word and isolate its lowest free bit
          hold_nxt    = ram_rdata;
          iso_nxt     = free_bits & (~free_bits + 1'b1);
          chk_vld_nxt = 1'b0;
          state_nxt   = S_AWR;
        end else if (chk_vld_r && chk_last_r) begin
          res_nxt.status = ST_FULL;
          chk_vld_nxt    = 1'b0;
          state_nxt      = S_EMIT;
        end else begin
          // Issue the next word while checking the previous one
          chk_vld_nxt = !iss_done_r;
          if (!iss_done_r) begin
            chk_word_nxt = rd_word_r;
            chk_base_nxt = rd_base_r;
            chk_mask_nxt = iss_mask;
            chk_last_nxt = iss_last;
            iss_done_nxt = iss_last;
            rd_word_nxt  = AW'(rd_word_r + 1'b1);
            rd_base_nxt  = rd_base_r + SCAN_SZ;
          end
        end
      end

      S_AWR: begin
        // Set the bit and count it
        ram_we    = 1'b1;
        ram_waddr = chk_word_r;
        ram_wdata = hold_r | iso_r;
        res_nxt.allocated_number = NUM_W'(chk_base_r + SZ_W'(enc) + 1'b1);
        if (used_r != USED_MAX) begin
          used_nxt = used_r + 1'b1;
        end
        state_nxt = S_EMIT;
      end

      S_FDIV: begin
        q_nxt     = prod[SZ_W+31:32];
        state_nxt = S_FCOR;
      end

      S_FCOR: begin
        // Correct the quotient estimate by at most one
        if (frem >= SCAN_SZ) begin
          fword_nxt = AW'(q_r + 1'b1);
          fbit_nxt  = BW'(frem - SCAN_SZ);
        end else begin
          fword_nxt = AW'(q_r);
          fbit_nxt  = BW'(frem);
        end
        state_nxt = S_FRD;
      end

      S_FRD: begin
        ram_raddr = fword_r;
        state_nxt = S_FWR;
      end

      S_FWR: begin
        // Clear the bit and lower the count
        ram_we    = 1'b1;
        ram_waddr = fword_r;
        ram_wdata = ram_rdata & ~(SCAN_WORD_BITS'(1) << fbit_r);
        if (used_r != '0) begin
          used_nxt = used_r - 1'b1;
        end
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        // Load the output register once it is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt            = res_r;
          out_data_nxt.used_count = used_r;
          state_nxt               = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      used_r      <= '0;
      map_size_r  <= MAP_SIZE_RESET;
      out_valid_r <= 1'b0;
      iss_done_r  <= 1'b0;
      chk_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      iss_done_r  <= iss_done_nxt;
      chk_vld_r   <= chk_vld_nxt;
      if (cfg_wen) begin
        map_size_r <= cfg_wdata;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    size_r     <= size_nxt;
    rd_word_r  <= rd_word_nxt;
    rd_base_r  <= rd_base_nxt;
    chk_word_r <= chk_word_nxt;
    chk_base_r <= chk_base_nxt;
    chk_mask_r <= chk_mask_nxt;
    chk_last_r <= chk_last_nxt;
    hold_r     <= hold_nxt;
    iso_r      <= iso_nxt;
    idx_r      <= idx_nxt;
    q_r        <= q_nxt;
    fword_r    <= fword_nxt;
    fbit_r     <= fbit_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // An accepted transaction keeps the input side busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("input taken again right after a transaction");

  // A full map never returns a number
  a_full_no_number: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == ST_FULL) |-> (out_data_r.allocated_number == '0))
    else $error("full status with a nonzero number");

  // An allocated number lies within the configured map size
  a_number_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.allocated_number != '0) |->
      (out_data_r.allocated_number <= map_size_r && out_data_r.status == ST_OK))
    else $error("allocated number beyond map size");

  // The isolated free bit is a single bit when written back
  a_iso_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_AWR) |-> $onehot(iso_r))
    else $error("allocation sets other than one bit");

endmodule

@@ tb/sv/tb_bitmap_first_free_allocator_top.sv @@
`timescale 1ns / 100ps

module tb_bitmap_first_free_allocator_top;
  import bfa_pkg::*;

  localparam int MAP_BITS     = DEF_MAP_BITS;
  localparam int WORD_COUNT   = (DEF_MAP_BITS + DEF_SCAN_WORD_BITS - 1) / DEF_SCAN_WORD_BITS;
  localparam int HOLD_CYCLES  = 600;
  localparam int LIMIT_CYCLES = 4000000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  bfa_in_t          in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  bfa_out_t         out_data;
  logic             cfg_wen = 1'b0;
  logic [NUM_W-1:0] cfg_wdata = '0;

  // Shadow of the allocator state
  bit [MAP_BITS-1:0] alloc_map_model;
  logic [NUM_W-1:0]  used_model;
  logic [NUM_W-1:0]  map_size_shadow;

  bfa_out_t pending_replies[$];
  int       live_entries[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  int fail_count = 0;
  int replies_checked = 0;
  int grants_seen = 0;
  int full_seen = 0;
  int range_seen = 0;
  int cycle_count = 0;

  bitmap_first_free_allocator_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int effective_size();
    return (map_size_shadow > MAP_BITS) ? MAP_BITS : int'(map_size_shadow);
  endfunction

  // Work out the reply to one request and advance the shadow state
  function automatic bfa_out_t predict_allocation(bfa_in_t req);
    bfa_out_t reply;
    int       eff;
    eff = effective_size();
    reply = '0;
    reply.status = ST_OK;
    if (req.operation == OP_ALLOC) begin
      reply.status = ST_FULL;
      for (int idx = 0; idx < eff; idx++) begin
        if (!alloc_map_model[idx]) begin
          alloc_map_model[idx] = 1'b1;
          reply.allocated_number = NUM_W'(idx + 1);
          reply.status = ST_OK;
          if (used_model != USED_MAX) used_model++;
          break;
        end
      end
    end else if (req.entry_number == 0 || req.entry_number > eff) begin
      reply.status = ST_RANGE;
    end else begin
      alloc_map_model[req.entry_number - 1] = 1'b0;
      if (used_model != 0) used_model--;
    end
    reply.used_count = used_model;
    return reply;
  endfunction

  // Offer one transaction, hold it until taken, then queue its reply
  task automatic send_request(input logic op, input logic [NUM_W-1:0] num);
    bfa_in_t  req;
    bfa_out_t reply;
    req.operation = op;
    req.entry_number = num;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_data <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    reply = predict_allocation(req);
    pending_replies.push_back(reply);
    if (op == OP_ALLOC && reply.status == ST_OK) live_entries.push_back(reply.allocated_number);
  endtask

  task automatic wait_results_drained();
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  // Write the map size once the block has gone quiet
  task automatic set_map_size(input logic [NUM_W-1:0] size);
    in_valid <= 1'b0;
    wait_results_drained();
    cfg_wdata <= size;
    cfg_wen <= 1'b1;
    @(posedge clk);
    cfg_wen <= 1'b0;
    map_size_shadow = size;
  endtask

  // Stall the reply channel: random, or a long hold when one is requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_requests != hold_served) begin
      hold_served <= hold_served + 1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Compare each accepted reply with the oldest queued one
  always @(posedge clk) begin
    bfa_out_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected reply %p", $time, out_data);
        fail_count++;
      end else begin
        want = pending_replies.pop_front();
        replies_checked++;
        if (want.status == ST_FULL) full_seen++;
        else if (want.status == ST_RANGE) range_seen++;
        else if (want.allocated_number != 0) grants_seen++;
        if (out_data.allocated_number !== want.allocated_number) begin
          $display("%0t: allocated_number expected %0d, got %0d", $time,
                   want.allocated_number, out_data.allocated_number);
          fail_count++;
        end
        if (out_data.status !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, out_data.status);
          fail_count++;
        end
        if (out_data.used_count !== want.used_count) begin
          $display("%0t: used_count expected %0d, got %0d", $time,
                   want.used_count, out_data.used_count);
          fail_count++;
        end
      end
    end
  end

  // Default size after reset: first grant, double free, range edges
  task automatic test_reset_defaults();
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, 14'd1);
    send_request(OP_FREE, 14'd1);
    send_request(OP_FREE, 14'd0);
    send_request(OP_FREE, 14'd8192);
    send_request(OP_FREE, 14'd8193);
    send_request(OP_FREE, 14'h3FFF);
    send_request(OP_ALLOC, 14'h3FFF);
  endtask

  // Zero size: every allocate is full, every free out of range
  task automatic test_empty_map();
    set_map_size(14'd0);
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, 14'd1);
  endtask

  // Size above the map is clamped to the map
  task automatic test_size_clamp();
    set_map_size(14'h3FFF);
    send_request(OP_FREE, 14'd8192);
    send_request(OP_FREE, 14'd8193);
    send_request(OP_ALLOC, '0);
  endtask

  // A shrunk size limits allocates and frees; a free above it is taken after growing it back
  task automatic test_shrunk_map();
    set_map_size(14'd1);
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, 14'd2);
    send_request(OP_FREE, 14'd1);
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, '0);
    set_map_size(14'd8192);
    send_request(OP_FREE, 14'd2);
  endtask

  // Mixed traffic over a spread of sizes; frees mostly target live entries
  task automatic test_random_traffic(input int pass_idx);
    int               phase_sizes[8];
    int               phase_items[8];
    int               eff;
    int               pick;
    int               idx;
    logic [NUM_W-1:0] num;
    phase_sizes = '{1, 32, 33, 300, 0, 16383, 100, 0};
    phase_items = '{20, 90, 90, 180, 10, 90, 70, 60};
    phase_sizes[7] = $urandom_range(8191, 2);
    for (int ph = 0; ph < 8; ph++) begin
      set_map_size(NUM_W'(phase_sizes[ph]));
      if (pass_idx == 0 && phase_sizes[ph] == 300) hold_requests <= hold_requests + 1;
      eff = effective_size();
      for (int n = 0; n < phase_items[ph]; n++) begin
        if ($urandom_range(99) < 55) begin
          send_request(OP_ALLOC, NUM_W'($urandom_range(16383, 0)));
        end else begin
          pick = $urandom_range(99);
          if (pick < 60 && live_entries.size() > 0) begin
            idx = $urandom_range(live_entries.size() - 1, 0);
            num = NUM_W'(live_entries[idx]);
            live_entries.delete(idx);
          end else if (pick < 80 && eff > 0) begin
            num = NUM_W'($urandom_range(eff, 1));
          end else if (pick < 90) begin
            num = $urandom_range(1) ? NUM_W'(0) : NUM_W'($urandom_range(16383, eff + 1));
          end else begin
            num = NUM_W'($urandom_range(16383, 0));
          end
          send_request(OP_FREE, num);
        end
      end
    end
  endtask

  initial begin
    alloc_map_model = '0;
    used_model = '0;
    map_size_shadow = MAP_SIZE_RESET;
    send_idle_pct = 37;
    recv_idle_pct = 57;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_empty_map();
    test_size_clamp();
    test_shrunk_map();

    // Receiver idles more, then sender idles more, then back to back
    test_random_traffic(0);
    send_idle_pct = 57;
    recv_idle_pct = 37;
    test_random_traffic(1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(2);

    in_valid <= 1'b0;
    wait_results_drained();
    repeat (WORD_COUNT + 8) @(posedge clk);

    $display("Checked %0d replies: %0d grants, %0d full-map replies, %0d out-of-range frees",
             replies_checked, grants_seen, full_seen, range_seen);
    $display("Map sizes covered zero, one, word edges, clamped maximum and a random size");
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
